// ===== sv/assert_macros.svh =====
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define ASSERT_AR(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_AR(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/mdlm_pkg.sv =====
package mdlm_pkg;

	localparam int unsigned SMP_W = 16;
	localparam int unsigned SUM_W = 24;
	localparam int unsigned CNT_W = 9;
	localparam int unsigned LVL_W = 10;

	localparam int unsigned GATE_FLOOR = 24;
	localparam int unsigned SCALE_SPAN = 900;
	localparam int unsigned LEVEL_MAX  = 1000;

	// x*1000/900 == (x*72820) >> 16 for x < 900
	localparam int unsigned SCALE_RECIP = 72820;
	// x/3 == (x*21846) >> 16 for x <= 3000
	localparam int unsigned THIRD_RECIP = 21846;
	localparam int unsigned RECIP_SHIFT = 16;

	// shift of the frame length reciprocal
	localparam int unsigned MEAN_SHIFT = 24;

	// pipeline stage slots
	localparam int unsigned NUM_STG = 7;
	localparam int unsigned STG_S1  = 0;
	localparam int unsigned STG_S2  = 1;
	localparam int unsigned STG_S3  = 2;
	localparam int unsigned STG_S4  = 3;
	localparam int unsigned STG_S5  = 4;
	localparam int unsigned STG_S6  = 5;
	localparam int unsigned STG_OUT = 6;

	typedef struct packed {
		logic [NUM_STG-1:0] ld;   // stage register loads this cycle
		logic [NUM_STG-1:0] vld;  // stage register holds an item
	} pipe_ctl_t;

endpackage

// ===== sv/mdlm_ctrl.sv =====
module mdlm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_ready,
	output logic                in_ready,
	output mdlm_pkg::pipe_ctl_t ctl
);

	logic [mdlm_pkg::NUM_STG-1:0] vld_q;
	logic [mdlm_pkg::NUM_STG-1:0] rdy;
	logic [mdlm_pkg::NUM_STG-1:0] vld_in;

	// a stage may load when it is empty or its content moves on
	always_comb begin
		rdy[mdlm_pkg::NUM_STG-1] = !vld_q[mdlm_pkg::NUM_STG-1] || out_ready;
		for (int k = mdlm_pkg::NUM_STG - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign vld_in = {vld_q[mdlm_pkg::NUM_STG-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < mdlm_pkg::NUM_STG; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	assign in_ready = rdy[mdlm_pkg::STG_S1];
	assign ctl.ld   = rdy;
	assign ctl.vld  = vld_q;

endmodule

// ===== sv/mdlm_front.sv =====
`include "assert_macros.svh"

module mdlm_front #(
	parameter int unsigned FRAME_SAMPLES = 320
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mdlm_pkg::pipe_ctl_t                ctl,
	input  logic signed [mdlm_pkg::SMP_W-1:0]  mic_a_sample,
	input  logic signed [mdlm_pkg::SMP_W-1:0]  mic_b_sample,
	output logic signed [mdlm_pkg::SMP_W-1:0]  mono_s3,
	output logic        [mdlm_pkg::SUM_W-1:0]  sum_s3,
	output logic                               close_s3
);

	localparam logic [mdlm_pkg::CNT_W-1:0] FRAME_LEN = mdlm_pkg::CNT_W'(FRAME_SAMPLES);

	logic signed [mdlm_pkg::SMP_W-1:0] a_s1;
	logic signed [mdlm_pkg::SMP_W-1:0] b_s1;
	logic signed [mdlm_pkg::SMP_W-1:0] mono_s2;
	logic signed [mdlm_pkg::SMP_W:0]   pair_sum;
	logic        [mdlm_pkg::SMP_W:0]   pair_adj;
	logic        [mdlm_pkg::SMP_W-1:0] mag;
	logic        [mdlm_pkg::SUM_W-1:0] acc_q;
	logic        [mdlm_pkg::SUM_W-1:0] sum_next;
	logic        [mdlm_pkg::CNT_W-1:0] cnt_q;
	logic        [mdlm_pkg::CNT_W-1:0] cnt_next;
	logic                              close;
	logic                              acc_upd;

	always_ff @(posedge clk) begin
		if (ctl.ld[mdlm_pkg::STG_S1]) begin
			a_s1 <= mic_a_sample;
			b_s1 <= mic_b_sample;
		end
	end

	// average toward zero: add one to a negative sum before the halving shift
	assign pair_sum = {a_s1[mdlm_pkg::SMP_W-1], a_s1} + {b_s1[mdlm_pkg::SMP_W-1], b_s1};
	assign pair_adj = pair_sum + {{mdlm_pkg::SMP_W{1'b0}}, pair_sum[mdlm_pkg::SMP_W]};

	always_ff @(posedge clk) begin
		if (ctl.ld[mdlm_pkg::STG_S2]) begin
			mono_s2 <= pair_adj[mdlm_pkg::SMP_W:1];
		end
	end

	// full-scale negative gives 32768, still fits unsigned
	assign mag      = mono_s2[mdlm_pkg::SMP_W-1] ? (~mono_s2 + 1'b1) : mono_s2;
	assign sum_next = acc_q + {{(mdlm_pkg::SUM_W - mdlm_pkg::SMP_W){1'b0}}, mag};
	assign cnt_next = cnt_q + 1'b1;
	assign close    = (cnt_next >= FRAME_LEN);
	assign acc_upd  = ctl.vld[mdlm_pkg::STG_S2] && ctl.ld[mdlm_pkg::STG_S3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (acc_upd) begin
			acc_q <= close ? '0 : sum_next;
			cnt_q <= close ? '0 : cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[mdlm_pkg::STG_S3]) begin
			mono_s3  <= mono_s2;
			sum_s3   <= sum_next;
			close_s3 <= close;
		end
	end

	`ASSERT_AR(a_cnt_in_frame, clk, arst_n, cnt_q < FRAME_LEN, "frame counter past frame length")
	`ASSERT_NEXT(a_acc_clear, clk, arst_n, acc_upd && close, acc_q == '0 && cnt_q == '0, "accumulator not cleared at frame end")

endmodule

// ===== sv/mdlm_mean.sv =====
module mdlm_mean #(
	parameter int unsigned FRAME_SAMPLES = 320
) (
	input  logic                               clk,
	input  mdlm_pkg::pipe_ctl_t                ctl,
	input  logic signed [mdlm_pkg::SMP_W-1:0]  mono_s3,
	input  logic        [mdlm_pkg::SUM_W-1:0]  sum_s3,
	input  logic                               close_s3,
	output logic signed [mdlm_pkg::SMP_W-1:0]  mono_s5,
	output logic        [mdlm_pkg::SUM_W-1:0]  mean_s5,
	output logic                               close_s5
);

	localparam int unsigned PROD_W = 2 * mdlm_pkg::SUM_W;
	localparam int unsigned QN_W   = mdlm_pkg::SUM_W + mdlm_pkg::CNT_W;
	localparam logic [mdlm_pkg::CNT_W-1:0] FRAME_LEN = mdlm_pkg::CNT_W'(FRAME_SAMPLES);
	localparam logic [mdlm_pkg::SUM_W:0] RECIP =
		(mdlm_pkg::SUM_W + 1)'((64'd1 << mdlm_pkg::MEAN_SHIFT) / FRAME_SAMPLES);

	logic signed [mdlm_pkg::SMP_W-1:0] mono_s4;
	logic        [mdlm_pkg::SUM_W-1:0] sum_s4;
	logic                              close_s4;
	logic        [PROD_W-1:0]          prod_s4;
	logic        [mdlm_pkg::SUM_W-1:0] q_est;
	logic        [QN_W-1:0]            qn;
	logic        [mdlm_pkg::SUM_W-1:0] rem;

	// estimate from the reciprocal is low by at most one
	always_ff @(posedge clk) begin
		if (ctl.ld[mdlm_pkg::STG_S4]) begin
			mono_s4  <= mono_s3;
			sum_s4   <= sum_s3;
			close_s4 <= close_s3;
			prod_s4  <= PROD_W'(sum_s3) * PROD_W'(RECIP);
		end
	end

	assign q_est = prod_s4[PROD_W-1:mdlm_pkg::MEAN_SHIFT];
	assign qn    = QN_W'(q_est) * QN_W'(FRAME_LEN);
	assign rem   = sum_s4 - qn[mdlm_pkg::SUM_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.ld[mdlm_pkg::STG_S5]) begin
			mono_s5  <= mono_s4;
			close_s5 <= close_s4;
			mean_s5  <= (rem >= mdlm_pkg::SUM_W'(FRAME_LEN)) ? q_est + 1'b1 : q_est;
		end
	end

endmodule

// ===== sv/mdlm_level.sv =====
`include "assert_macros.svh"

module mdlm_level (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mdlm_pkg::pipe_ctl_t                ctl,
	input  logic signed [mdlm_pkg::SMP_W-1:0]  mono_s5,
	input  logic        [mdlm_pkg::SUM_W-1:0]  mean_s5,
	input  logic                               close_s5,
	output logic signed [mdlm_pkg::SMP_W-1:0]  mono_q,
	output logic        [mdlm_pkg::LVL_W-1:0]  level_q,
	output logic                               frame_end_q
);

	localparam int unsigned SPROD_W = 27;
	localparam int unsigned TOT_W   = mdlm_pkg::LVL_W + 2;
	localparam int unsigned LPROD_W = 28;

	logic [mdlm_pkg::SUM_W-1:0] over;
	logic [SPROD_W-1:0]         sprod;
	logic                       gate_s6;
	logic                       sat_s6;
	logic                       close_s6;
	logic signed [mdlm_pkg::SMP_W-1:0] mono_s6;
	logic [mdlm_pkg::LVL_W-1:0] scaled_s6;
	logic [mdlm_pkg::LVL_W-1:0] target;
	logic [TOT_W-1:0]           total;
	logic [LPROD_W-1:0]         lprod;
	logic                       lvl_upd;

	assign over  = mean_s5 - mdlm_pkg::SUM_W'(mdlm_pkg::GATE_FLOOR);
	assign sprod = SPROD_W'(over[mdlm_pkg::LVL_W-1:0]) * SPROD_W'(mdlm_pkg::SCALE_RECIP);

	always_ff @(posedge clk) begin
		if (ctl.ld[mdlm_pkg::STG_S6]) begin
			mono_s6   <= mono_s5;
			close_s6  <= close_s5;
			gate_s6   <= (mean_s5 <= mdlm_pkg::SUM_W'(mdlm_pkg::GATE_FLOOR));
			sat_s6    <= (over >= mdlm_pkg::SUM_W'(mdlm_pkg::SCALE_SPAN));
			scaled_s6 <= sprod[mdlm_pkg::RECIP_SHIFT +: mdlm_pkg::LVL_W];
		end
	end

	always_comb begin
		priority if (gate_s6) begin
			target = '0;
		end else if (sat_s6) begin
			target = mdlm_pkg::LVL_W'(mdlm_pkg::LEVEL_MAX);
		end else begin
			target = scaled_s6;
		end
	end

	// level = (2*level + target) / 3
	assign total   = {1'b0, level_q, 1'b0} + TOT_W'(target);
	assign lprod   = LPROD_W'(total) * LPROD_W'(mdlm_pkg::THIRD_RECIP);
	assign lvl_upd = ctl.vld[mdlm_pkg::STG_S6] && ctl.ld[mdlm_pkg::STG_OUT] && close_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (lvl_upd) begin
			level_q <= lprod[mdlm_pkg::RECIP_SHIFT +: mdlm_pkg::LVL_W];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[mdlm_pkg::STG_OUT]) begin
			mono_q      <= mono_s6;
			frame_end_q <= close_s6;
		end
	end

	`ASSERT_AR(a_level_range, clk, arst_n, level_q <= mdlm_pkg::LVL_W'(mdlm_pkg::LEVEL_MAX), "level above full scale")
	`ASSERT_NEXT(a_level_hold, clk, arst_n, !lvl_upd, $stable(level_q), "level moved without a frame end")

endmodule

// ===== sv/mic_downmix_level_meter_top.sv =====
// Two-microphone downmix with a mean-absolute level meter. Every item carries one
// sample per microphone slot and yields exactly one result: the mono average
// (truncated toward zero), the current smoothed level (0..1000) and a frame_end
// flag on the sample that closes a frame of FRAME_SAMPLES samples. Throughput is
// one item per clock while the output is not stalled. The register stages are the
// input register, the downmix, the accumulator, the two-step divide by the frame
// length (reciprocal multiply, then one-step correction), the gate and scale
// multiply, and the smoothing multiply into the output register. Each stage
// has its own valid bit, so bubbles collapse under back-pressure and an item is
// taken while a finished result still waits. No clearing pass after reset.
module mic_downmix_level_meter_top #(
	parameter int unsigned FRAME_SAMPLES = 320
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [15:0] mic_a_sample, [31:16] mic_b_sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [15:0] mono_sample, [25:16] level, zero above
	output logic        m_axis_tuser    // [0] frame_end
);

	mdlm_pkg::pipe_ctl_t ctl;

	logic signed [mdlm_pkg::SMP_W-1:0] mono_s3;
	logic        [mdlm_pkg::SUM_W-1:0] sum_s3;
	logic                              close_s3;
	logic signed [mdlm_pkg::SMP_W-1:0] mono_s5;
	logic        [mdlm_pkg::SUM_W-1:0] mean_s5;
	logic                              close_s5;
	logic signed [mdlm_pkg::SMP_W-1:0] mono_q;
	logic        [mdlm_pkg::LVL_W-1:0] level_q;
	logic                              frame_end_q;

	mdlm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.out_ready (m_axis_tready),
		.in_ready  (s_axis_tready),
		.ctl       (ctl)
	);

	mdlm_front #(
		.FRAME_SAMPLES (FRAME_SAMPLES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.mic_a_sample (s_axis_tdata[15:0]),
		.mic_b_sample (s_axis_tdata[31:16]),
		.mono_s3      (mono_s3),
		.sum_s3       (sum_s3),
		.close_s3     (close_s3)
	);

	mdlm_mean #(
		.FRAME_SAMPLES (FRAME_SAMPLES)
	) u_mean (
		.clk      (clk),
		.ctl      (ctl),
		.mono_s3  (mono_s3),
		.sum_s3   (sum_s3),
		.close_s3 (close_s3),
		.mono_s5  (mono_s5),
		.mean_s5  (mean_s5),
		.close_s5 (close_s5)
	);

	mdlm_level u_level (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.mono_s5     (mono_s5),
		.mean_s5     (mean_s5),
		.close_s5    (close_s5),
		.mono_q      (mono_q),
		.level_q     (level_q),
		.frame_end_q (frame_end_q)
	);

	assign m_axis_tvalid = ctl.vld[mdlm_pkg::STG_OUT];
	assign m_axis_tdata  = {6'b0, level_q, mono_q};
	assign m_axis_tuser  = frame_end_q;

endmodule

// ===== sim/mic_downmix_level_meter_checker.sv =====
`timescale 1ns / 1ps

module mic_downmix_level_meter_checker #(
	parameter int unsigned FRAME_SAMPLES = 320
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [15:0] mic_a_sample, [31:16] mic_b_sample
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,   // [15:0] mono_sample, [25:16] level, zero above
	input  logic        m_axis_tuser,   // [0] frame_end
	output int          fail_count,
	output int          pending,
	output int          checked,
	output int          frames,
	output int          peak_level
);

	localparam int unsigned FRAME_LEN  = (FRAME_SAMPLES < 1) ? 1 : FRAME_SAMPLES;
	localparam int unsigned GATE_FLOOR = 24;
	localparam int unsigned SCALE_SPAN = 900;
	localparam int unsigned LEVEL_FULL = 1000;

	typedef struct {
		logic [15:0] mono;
		logic [9:0]  level;
		logic        frame_end;
	} meter_result_t;

	meter_result_t expected_results[$];

	logic [23:0] frame_abs_sum;
	logic [8:0]  frame_count;
	logic [9:0]  held_level;
	int          predicted;

	assign pending = predicted - checked;

	// Downmix one pair and advance the frame meter.
	function automatic meter_result_t downmix_and_meter(logic [15:0] mic_a, logic [15:0] mic_b);
		meter_result_t r;
		int            mono;
		int unsigned   mag;
		int unsigned   mean;
		int unsigned   over;
		int unsigned   target;
		mono = (int'($signed(mic_a)) + int'($signed(mic_b))) / 2;
		mag = (mono < 0) ? -mono : mono;
		frame_abs_sum = frame_abs_sum + 24'(mag);
		frame_count = frame_count + 9'd1;
		r.frame_end = 1'b0;
		if (frame_count >= FRAME_LEN) begin
			mean = frame_abs_sum / FRAME_LEN;
			if (mean <= GATE_FLOOR) begin
				target = 0;
			end else begin
				over = mean - GATE_FLOOR;
				target = (over >= SCALE_SPAN) ? LEVEL_FULL : over * LEVEL_FULL / SCALE_SPAN;
			end
			held_level = 10'((2 * int'(held_level) + target) / 3);
			frame_abs_sum = '0;
			frame_count = '0;
			r.frame_end = 1'b1;
		end
		r.mono = 16'(mono);
		r.level = held_level;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at result %0d: %s is %0d, expected %0d", checked, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		meter_result_t want;
		if (!arst_n) begin
			frame_abs_sum = '0;
			frame_count = '0;
			held_level = '0;
			expected_results.delete();
			fail_count = 0;
			predicted <= 0;
			checked <= 0;
			frames <= 0;
			peak_level <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(
					downmix_and_meter(s_axis_tdata[15:0], s_axis_tdata[31:16]));
				predicted <= predicted + 1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				checked <= checked + 1;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected item, mono_sample",
						int'($signed(m_axis_tdata[15:0])), 0);
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tdata[15:0] !== want.mono)
						report_mismatch("mono_sample", int'($signed(m_axis_tdata[15:0])),
							int'($signed(want.mono)));
					if (m_axis_tdata[25:16] !== want.level)
						report_mismatch("level", int'(m_axis_tdata[25:16]), int'(want.level));
					if (m_axis_tdata[31:26] !== 6'd0)
						report_mismatch("tdata padding", int'(m_axis_tdata[31:26]), 0);
					if (m_axis_tuser !== want.frame_end)
						report_mismatch("frame_end", int'(m_axis_tuser), int'(want.frame_end));
					if (want.frame_end)
						frames <= frames + 1;
					if (int'(want.level) > peak_level)
						peak_level <= int'(want.level);
				end
			end
		end
	end

endmodule

// ===== sim/tb_mic_downmix_level_meter_top.sv =====
`timescale 1ns / 1ps

module tb_mic_downmix_level_meter_top;

	localparam int unsigned FRAME_LEN    = 320;
	localparam int unsigned ITEM_TOTAL   = 1950;
	localparam int unsigned HOLD_CYCLES  = 160;
	localparam int unsigned DRAIN_CYCLES = 30;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	typedef enum int {
		KIND_FULL_NEG,
		KIND_LOUD,
		KIND_MID,
		KIND_NEAR_GATE,
		KIND_SILENT,
		KIND_CONST,
		KIND_NOISE
	} frame_kind_e;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;

	int fail_count;
	int pending;
	int checked;
	int frames;
	int peak_level;

	int hold_req;
	int sent;
	int cycle_count;

	mic_downmix_level_meter_top #(
		.FRAME_SAMPLES(FRAME_LEN)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	mic_downmix_level_meter_checker #(
		.FRAME_SAMPLES(FRAME_LEN)
	) meter_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.fail_count   (fail_count),
		.pending      (pending),
		.checked      (checked),
		.frames       (frames),
		.peak_level   (peak_level)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Offer one pair and hold it until the block takes it.
	task automatic send_pair(input logic [15:0] mic_a, input logic [15:0] mic_b);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {mic_b, mic_a};
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	// Sample pair shaped by the loudness class of the current frame.
	task automatic make_pair(input frame_kind_e kind, input int unsigned cval,
			output logic [15:0] mic_a, output logic [15:0] mic_b);
		int x;
		int d;
		int sgn;
		case (kind)
			KIND_FULL_NEG: begin
				mic_a = 16'h8000;
				mic_b = 16'h8000;
			end
			KIND_LOUD: begin
				mic_a = 16'($urandom);
				mic_b = mic_a ^ 16'($urandom_range(0, 255));
			end
			KIND_MID: begin
				x = int'($urandom_range(0, 3000)) - 1500;
				mic_a = 16'(x);
				mic_b = 16'(x + int'($urandom_range(0, 40)) - 20);
			end
			KIND_NEAR_GATE: begin
				x = int'($urandom_range(0, 112)) - 56;
				mic_a = 16'(x);
				mic_b = 16'(x + int'($urandom_range(0, 4)) - 2);
			end
			KIND_SILENT: begin
				x = int'($urandom_range(0, 60)) - 30;
				mic_a = 16'(x);
				mic_b = 16'(x + int'($urandom_range(0, 4)) - 2);
			end
			KIND_CONST: begin
				// a+b is always 2*cval, so every mono magnitude is exactly cval
				d = int'($urandom_range(0, 20));
				sgn = $urandom_range(0, 1) ? -1 : 1;
				mic_a = 16'(sgn * (int'(cval) + d));
				mic_b = 16'(sgn * (int'(cval) - d));
			end
			default: begin
				mic_a = 16'($urandom);
				mic_b = 16'($urandom);
			end
		endcase
		if (kind != KIND_CONST && $urandom_range(0, 15) == 0) begin
			mic_a = 16'($urandom);
			mic_b = 16'($urandom);
		end
	endtask

	initial begin
		logic [15:0]  a;
		logic [15:0]  b;
		int           burst;
		int           gap;
		int unsigned  cval;
		frame_kind_e  kind;
		bit           held;
		bit           drained;
		bit           drain_now;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		arst_n <= 1'b0;
		hold_req <= 0;
		sent = 0;
		held = 0;
		drained = 0;
		drain_now = 0;
		cval = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes and rounding toward zero
		send_pair(16'h8000, 16'h8000);   // both at minimum, magnitude 32768
		send_pair(16'h7fff, 16'h7fff);
		send_pair(16'h7fff, 16'h8000);   // sum -1 -> 0
		send_pair(16'h8000, 16'h7fff);
		send_pair(16'hffff, 16'h0000);
		send_pair(16'h0000, 16'hffff);
		send_pair(16'h0001, 16'h0000);
		send_pair(16'hfffd, 16'h0000);   // -3/2 -> -1
		send_pair(16'h0003, 16'h0000);
		send_pair(16'h8000, 16'h0000);
		send_pair(16'h7fff, 16'h0000);
		send_pair(16'h0000, 16'h0000);
		send_pair(16'h8001, 16'h8000);
		send_pair(16'h7fff, 16'h7ffe);
		send_pair(16'h5555, 16'haaaa);
		send_pair(16'haaaa, 16'h5555);
		send_pair(16'h0001, 16'hfffe);
		send_pair(16'hfffe, 16'h0001);

		// frame 0 finishes near full scale, later frames step through the classes
		kind = KIND_FULL_NEG;
		while (sent < ITEM_TOTAL) begin
			burst = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (!held && sent >= 600) begin
				// output side holds off while this burst keeps coming
				held = 1;
				hold_req <= hold_req + 1;
				burst = 48;
				gap = 0;
			end else if (!drained && sent >= 1250) begin
				drained = 1;
				drain_now = 1;
				if (gap == 0)
					gap = 1;
			end
			for (int i = 0; i < burst && sent < ITEM_TOTAL; i++) begin
				if (sent % FRAME_LEN == 0) begin
					case (sent / FRAME_LEN)
						1: kind = KIND_LOUD;
						2: begin
							kind = KIND_CONST;
							cval = $urandom_range(923, 924);   // saturation edge
						end
						3: kind = KIND_SILENT;
						4: begin
							kind = KIND_CONST;
							cval = $urandom_range(24, 25);     // gate edge
						end
						5: kind = KIND_MID;
						default: begin
							kind = frame_kind_e'($urandom_range(0, 6));
							cval = $urandom_range(0, 1000);
						end
					endcase
				end
				make_pair(kind, cval, a, b);
				send_pair(a, b);
			end
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
				if (drain_now) begin
					drain_now = 0;
					while (pending != 0) @(posedge clk);
				end
			end
		end
		s_axis_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d sample pairs sent in random bursts, with a long output hold-off and a drain",
			sent);
		$display("%0d items checked, %0d frames closed, peak level %0d", checked, frames,
			peak_level);
		if (fail_count == 0 && pending == 0)
			$display("tb_mic_downmix_level_meter_top passed");
		else
			$display("tb_mic_downmix_level_meter_top failed");
		$finish;
	end

	// Output side: stall modes change at random; a hold-off request stalls for a long stretch.
	initial begin
		int   mode;
		int   mode_left;
		int   hold_done;
		int   phase;
		logic rdy;
		m_axis_tready <= 1'b0;
		mode = 0;
		mode_left = 0;
		hold_done = 0;
		phase = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req != hold_done) begin
				hold_done = hold_req;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 4);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			phase++;
			case (mode)
				0: rdy = 1'b1;
				1: rdy = 1'($urandom_range(0, 1));
				2: rdy = ($urandom_range(0, 7) != 0);
				3: rdy = ($urandom_range(0, 3) == 0);
				default: rdy = (phase % 3 != 0);
			endcase
			m_axis_tready <= rdy;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d items outstanding", cycle_count, pending);
		$display("tb_mic_downmix_level_meter_top failed");
		$finish;
	end

endmodule
